// ----- hw/rtl/spfa_pkg.sv -----
// ---------------------------------------------------------------------------
// spfa_pkg
// Types, codes and constants shared by the single-precision adder files.
// ---------------------------------------------------------------------------
package spfa_pkg;

   localparam int WordWidth   = 32;
   localparam int ExpWidth    = 8;
   localparam int FracWidth   = 23;
   localparam int StatusWidth = 3;

   localparam logic [ExpWidth-1:0]  ExpMax   = 8'hFF;
   localparam logic [WordWidth-1:0] QnanWord = 32'h7FC0_0000;
   localparam logic [WordWidth-1:0] PinfWord = 32'h7F80_0000;
   localparam logic [WordWidth-1:0] NinfWord = 32'hFF80_0000;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_NORMAL = 3'd0,
      STATUS_NAN    = 3'd1,
      STATUS_PINF   = 3'd2,
      STATUS_NINF   = 3'd3,
      STATUS_OVER   = 3'd4,
      STATUS_UNDER  = 3'd5
   } status_type;

   typedef struct packed {
      logic [WordWidth-1:0] operand_a;
      logic [WordWidth-1:0] operand_b;
   } req_word_type;

   typedef struct packed {
      logic [WordWidth-1:0]   sum_bits;
      logic [StatusWidth-1:0] status;
   } rsp_word_type;

endpackage

// ----- hw/rtl/spfa_lzc.sv -----
// ---------------------------------------------------------------------------
// spfa_lzc
// Leading-zero count of a 24-bit significand.
// ---------------------------------------------------------------------------
module spfa_lzc
   import spfa_pkg::*;
(
   input  logic [23:0] value,
   output logic [4:0]  count
);

   // Priority encoder: the highest set bit wins.
   always_comb begin
      count = 5'd24;
      for (int i = 0; i < 24; i++) begin
         if (value[i]) begin
            count = 5'(23 - i);
         end
      end
   end

endmodule

// ----- hw/rtl/single_precision_float_adder_core.sv -----
// ---------------------------------------------------------------------------
// single_precision_float_adder_core
// Four-stage pipelined single-precision adder with a status code.
// ---------------------------------------------------------------------------
//
//   channel  valid      stall      word                    direction
//   request  req_valid  req_stall  req_word (two operands)  in
//   response rsp_valid  rsp_stall  rsp_word (sum, status)   out
//
// Each word passes four register stages: unpack and compare, align and add,
// magnitude and leading-zero count, normalize and pack. A word accepted into the
// first stage moves through the second and third and shows on rsp_valid from the
// fourth, which it leaves when rsp_stall is low. A new word may enter every cycle while req_stall is low.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// A stall on the response side holds the last stage; earlier stages keep
// moving into empty slots, so bubbles are squeezed out before req_stall rises.
module single_precision_float_adder_core
   import spfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   // Stage enables: a stage loads when it is empty or the next one loads.
   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------- Stage 1: classify, unpack, order by exponent ----------
   logic [31:0] a, b;
   logic [7:0]  ea_raw, eb_raw, ea, eb;
   logic        a_nan, b_nan, a_inf, b_inf;
   logic        spec_in;
   logic [31:0] spec_bits_in;
   status_type  spec_st_in;
   logic [23:0] ma, mb;
   logic        swap;
   logic [7:0]  diff;

   logic        s1_spec_ff;
   logic [31:0] s1_spec_bits_ff;
   status_type  s1_spec_st_ff;
   logic [7:0]  s1_exp_ff;
   logic [23:0] s1_big_ff, s1_small_ff;
   logic        s1_big_sign_ff, s1_small_sign_ff;
   logic [4:0]  s1_diff_ff;

   assign a = req_word.operand_a;
   assign b = req_word.operand_b;
   assign ea_raw = a[30:23];
   assign eb_raw = b[30:23];
   assign a_nan = (ea_raw == ExpMax) && (a[22:0] != '0);
   assign b_nan = (eb_raw == ExpMax) && (b[22:0] != '0);
   assign a_inf = (ea_raw == ExpMax) && (a[22:0] == '0);
   assign b_inf = (eb_raw == ExpMax) && (b[22:0] == '0);

   always_comb begin
      spec_in      = 1'b1;
      spec_bits_in = QnanWord;
      spec_st_in   = STATUS_NAN;
      if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
         spec_bits_in = QnanWord;
         spec_st_in   = STATUS_NAN;
      end else if (a_inf || b_inf) begin
         // The infinite operand sets the sign; both agree when both are.
         if (a_inf ? a[31] : b[31]) begin
            spec_bits_in = NinfWord;
            spec_st_in   = STATUS_NINF;
         end else begin
            spec_bits_in = PinfWord;
            spec_st_in   = STATUS_PINF;
         end
      end else begin
         spec_in = 1'b0;
      end
   end

   // Denormals take exponent one with a hidden zero.
   assign ma   = {(ea_raw != '0), a[22:0]};
   assign mb   = {(eb_raw != '0), b[22:0]};
   assign ea   = (ea_raw == '0) ? 8'd1 : ea_raw;
   assign eb   = (eb_raw == '0) ? 8'd1 : eb_raw;
   assign swap = ea < eb;
   assign diff = swap ? (eb - ea) : (ea - eb);

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_spec_ff       <= spec_in;
         s1_spec_bits_ff  <= spec_bits_in;
         s1_spec_st_ff    <= spec_st_in;
         s1_exp_ff        <= swap ? eb : ea;
         s1_big_ff        <= swap ? mb : ma;
         s1_small_ff      <= swap ? ma : mb;
         s1_big_sign_ff   <= swap ? b[31] : a[31];
         s1_small_sign_ff <= swap ? a[31] : b[31];
         // Any distance past 25 behaves the same, so clamp it.
         s1_diff_ff       <= (diff > 8'd26) ? 5'd26 : diff[4:0];
      end
   end

   // ---------------- Stage 2: align with round-up, two's-complement add ----
   logic [24:0] shifted;
   logic [24:0] aligned;
   logic [25:0] t_big, t_small;

   logic        s2_spec_ff;
   logic [31:0] s2_spec_bits_ff;
   status_type  s2_spec_st_ff;
   logic [7:0]  s2_exp_ff;
   logic [25:0] s2_sum_ff;

   // The guard is the last bit shifted out; it lands in bit zero here.
   assign shifted = {s1_small_ff, 1'b0} >> s1_diff_ff;
   assign aligned = {1'b0, shifted[24:1]} + {24'd0, shifted[0]};
   assign t_big   = s1_big_sign_ff ? (26'd0 - {2'b00, s1_big_ff}) : {2'b00, s1_big_ff};
   assign t_small = s1_small_sign_ff ? (26'd0 - {1'b0, aligned}) : {1'b0, aligned};

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_spec_ff      <= s1_spec_ff;
         s2_spec_bits_ff <= s1_spec_bits_ff;
         s2_spec_st_ff   <= s1_spec_st_ff;
         s2_exp_ff       <= s1_exp_ff;
         s2_sum_ff       <= t_big + t_small;
      end
   end

   // ---------------- Stage 3: sign, magnitude, leading zeros ---------------
   logic [24:0] mag_full;
   logic [4:0]  lz;

   logic        s3_spec_ff;
   logic [31:0] s3_spec_bits_ff;
   status_type  s3_spec_st_ff;
   logic [7:0]  s3_exp_ff;
   logic        s3_neg_ff;
   logic [24:0] s3_mag_ff;
   logic [4:0]  s3_lz_ff;

   // The magnitude always fits in 25 bits.
   assign mag_full = s2_sum_ff[25] ? 25'(26'd0 - s2_sum_ff) : s2_sum_ff[24:0];

   spfa_lzc u_lzc (
      .value (mag_full[23:0]),
      .count (lz)
   );

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_spec_ff      <= s2_spec_ff;
         s3_spec_bits_ff <= s2_spec_bits_ff;
         s3_spec_st_ff   <= s2_spec_st_ff;
         s3_exp_ff       <= s2_exp_ff;
         s3_neg_ff       <= s2_sum_ff[25];
         s3_mag_ff       <= mag_full;
         s3_lz_ff        <= lz;
      end
   end

   // ---------------- Stage 4: normalize, range check, pack -----------------
   logic [24:0]  m1;
   logic         twice;
   logic [7:0]   exp_right;
   logic [23:0]  left_sig;
   logic [7:0]   exp_left;
   rsp_word_type rsp_in;
   rsp_word_type rsp_word_ff;

   // A right shift whose round-up carries out needs a second shift.
   // The exponent is only packed when it stays below 255, so 8 bits suffice.
   assign m1        = {1'b0, s3_mag_ff[24:1]} + {24'd0, s3_mag_ff[0]};
   assign twice     = m1[24];
   assign exp_right = s3_exp_ff + 8'd1 + {7'd0, twice};
   assign left_sig  = s3_mag_ff[23:0] << s3_lz_ff;
   assign exp_left  = s3_exp_ff - {3'b000, s3_lz_ff};

   always_comb begin
      rsp_in.sum_bits = '0;
      rsp_in.status   = STATUS_NORMAL;
      if (s3_spec_ff) begin
         rsp_in.sum_bits = s3_spec_bits_ff;
         rsp_in.status   = s3_spec_st_ff;
      end else if (s3_mag_ff == '0) begin
         // An exact zero is always plus zero.
         rsp_in.sum_bits = '0;
         rsp_in.status   = STATUS_NORMAL;
      end else if (s3_mag_ff[24]) begin
         if (s3_exp_ff >= 8'd254 || (twice && s3_exp_ff >= 8'd253)) begin
            rsp_in.status = STATUS_OVER;
         end else begin
            rsp_in.sum_bits = {s3_neg_ff, exp_right,
                               twice ? 23'd0 : m1[22:0]};
         end
      end else if ({3'b000, s3_lz_ff} >= s3_exp_ff) begin
         rsp_in.status = STATUS_UNDER;
      end else begin
         rsp_in.sum_bits = {s3_neg_ff, exp_left, left_sig[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rsp_word_ff <= rsp_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hw/rtl/spfa_checker.sv -----
// ---------------------------------------------------------------------------
// spfa_checker
// Port-level assertions for the single-precision adder, bound to the core.
// ---------------------------------------------------------------------------
module spfa_checker
   import spfa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input rsp_word_type rsp_word,
   input logic         rsp_valid,
   input logic         rsp_stall
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed under stall");

   // Nothing comes out of the pipeline right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The input only backs up when the output side is stalling.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_stall)
      else $error("request stalled without a response stall");

   // Range errors always carry a zero word.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status == STATUS_OVER || rsp_word.status == STATUS_UNDER)
      |-> rsp_word.sum_bits == '0)
      else $error("range error with nonzero sum");

   // A normal result is a normal number or plus zero.
   a_normal_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STATUS_NORMAL
      |-> rsp_word.sum_bits[30:23] != ExpMax
          && (rsp_word.sum_bits[30:23] != '0 || rsp_word.sum_bits == '0))
      else $error("normal status with malformed sum");

endmodule

bind single_precision_float_adder_core spfa_checker u_spfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_word  (rsp_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);
